// File: hdl/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define S2HR_ASSERT(label, clk_i, rstn_i, cond) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (cond)) \
        else $error("s2hr assertion failed");

// consequent must hold in the same cycle as the antecedent
`define S2HR_IMPLIES(label, clk_i, rstn_i, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("s2hr assertion failed");

`endif

// File: hdl/s2hr_pkg.sv
// types, constants and helpers for the size formatting pipeline
package s2hr_pkg;

    localparam int COUNT_W = 63;
    localparam int Q_W     = 10;
    localparam int R_W     = 10;
    localparam int STEP_W  = 3;
    localparam int VAL_W   = 11;
    localparam int DIG_W   = 4;
    localparam int CHAR_W  = 8;

    localparam int MAX_STEPS = 6;

    localparam logic [63:0] SMALL_LIMIT = 64'd1000;
    localparam logic [10:0] CARRY_LIMIT = 11'd999;
    localparam logic [9:0]  HALF_LIMIT  = 10'd500;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31;

    // quotient and last remainder after the 1024 divisions
    typedef struct packed {
        logic [STEP_W-1:0] steps;
        logic [Q_W-1:0]    q;
        logic [R_W-1:0]    r;
    } range_t;

    // rounded value ready for printing
    typedef struct packed {
        logic [STEP_W-1:0] steps;
        logic              short_fmt;
        logic [VAL_W-1:0]  value;
        logic [DIG_W-1:0]  frac;
    } value_t;

    function automatic logic [CHAR_W-1:0] unit_char(input logic [STEP_W-1:0] steps);
        logic [CHAR_W-1:0] c;
        case (steps)
            3'd0:    c = 8'h42;  // B
            3'd1:    c = 8'h4B;  // K
            3'd2:    c = 8'h4D;  // M
            3'd3:    c = 8'h47;  // G
            3'd4:    c = 8'h54;  // T
            3'd5:    c = 8'h50;  // P
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        return CHAR_ZERO + {4'b0000, d};
    endfunction

endpackage

// File: hdl/s2hr_range.sv
// step count and quotient/remainder extraction, two pipeline stages
module s2hr_range (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [s2hr_pkg::COUNT_W-1:0]    byte_count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output s2hr_pkg::range_t                out_data
);

    logic                           va_reg;
    logic                           vb_reg;
    logic                           adv_a;
    logic                           adv_b;
    logic [s2hr_pkg::COUNT_W-1:0]   count_reg;
    logic [s2hr_pkg::STEP_W-1:0]    steps_reg;
    logic [s2hr_pkg::STEP_W-1:0]    steps_next;
    s2hr_pkg::range_t               range_reg;
    s2hr_pkg::range_t               range_next;

    assign adv_b    = !vb_reg || out_ready;
    assign adv_a    = !va_reg || adv_b;
    assign in_ready = adv_a;

    // number of divisions: count of thresholds 1000 << 10k that are reached
    always_comb
    begin
        steps_next = '0;
        for (int k = 0; k < s2hr_pkg::MAX_STEPS; k++)
        begin
            if ({1'b0, byte_count} >= (s2hr_pkg::SMALL_LIMIT << (10 * k)))
            begin
                steps_next = steps_next + 3'd1;
            end
        end
    end

    // window of the count at the chosen step
    always_comb
    begin
        range_next.steps = steps_reg;
        case (steps_reg)
            3'd0:
            begin
                range_next.q = count_reg[9:0];
                range_next.r = '0;
            end
            3'd1:
            begin
                range_next.q = count_reg[19:10];
                range_next.r = count_reg[9:0];
            end
            3'd2:
            begin
                range_next.q = count_reg[29:20];
                range_next.r = count_reg[19:10];
            end
            3'd3:
            begin
                range_next.q = count_reg[39:30];
                range_next.r = count_reg[29:20];
            end
            3'd4:
            begin
                range_next.q = count_reg[49:40];
                range_next.r = count_reg[39:30];
            end
            3'd5:
            begin
                range_next.q = count_reg[59:50];
                range_next.r = count_reg[49:40];
            end
            default:
            begin
                range_next.q = {7'd0, count_reg[62:60]};
                range_next.r = count_reg[59:50];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                va_reg <= in_valid;
            end
            if (adv_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && in_valid)
        begin
            count_reg <= byte_count;
            steps_reg <= steps_next;
        end
        if (adv_b && va_reg)
        begin
            range_reg <= range_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = range_reg;

endmodule

// File: hdl/s2hr_round.sv
// remainder rounding, carry and final value selection, three stages
module s2hr_round (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  s2hr_pkg::range_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output s2hr_pkg::value_t    out_data
);

    logic        va_reg;
    logic        vb_reg;
    logic        vc_reg;
    logic        adv_a;
    logic        adv_b;
    logic        adv_c;

    // stage a: remainder rounded at the units digit
    logic [2:0]  steps_a_reg;
    logic [9:0]  q_a_reg;
    logic [6:0]  tens_a_reg;
    logic [10:0] r1_a_reg;
    logic [10:0] r_plus;
    logic [23:0] tens_prod;
    logic [6:0]  tens_next;
    logic [10:0] tens_x10;
    logic [10:0] r1_next;

    // stage b: second rounding and carry into the quotient
    logic [2:0]  steps_b_reg;
    logic [10:0] qc_b_reg;
    logic [9:0]  rf_b_reg;
    logic [14:0] td_prod;
    logic [3:0]  td;
    logic [6:0]  td_x10;
    logic [6:0]  d2_full;
    logic [3:0]  d2;
    logic [3:0]  up;
    logic [6:0]  add_amt;
    logic [10:0] r2;
    logic        carry;
    logic [10:0] qc_next;
    logic [9:0]  rf_next;

    // stage c: format choice
    s2hr_pkg::value_t value_reg;
    s2hr_pkg::value_t value_next;
    logic [22:0] frac_prod;

    assign adv_c    = !vc_reg || out_ready;
    assign adv_b    = !vb_reg || adv_c;
    assign adv_a    = !va_reg || adv_b;
    assign in_ready = adv_a;

    always_comb
    begin
        r_plus    = {1'b0, in_data.r} + 11'd5;
        tens_prod = 24'(r_plus) * 24'd6554;
        tens_next = tens_prod[22:16];
        tens_x10  = ({4'd0, tens_next} << 3) + ({4'd0, tens_next} << 1);
        // rounded up exactly when the tens multiple passes the remainder
        r1_next   = (tens_x10 > {1'b0, in_data.r}) ? tens_x10 : {1'b0, in_data.r};
    end

    always_comb
    begin
        td_prod = 15'(tens_a_reg) * 15'd205;
        td      = td_prod[14:11];
        td_x10  = ({3'd0, td} << 3) + ({3'd0, td} << 1);
        d2_full = tens_a_reg - td_x10;
        d2      = d2_full[3:0];
        up      = 4'd10 - d2;
        add_amt = ({3'd0, up} << 3) + ({3'd0, up} << 1);
        r2      = r1_a_reg + ((d2 > 4'd4) ? {4'd0, add_amt} : 11'd0);
        carry   = r2 > s2hr_pkg::CARRY_LIMIT;
        qc_next = {1'b0, q_a_reg} + {10'd0, carry};
        rf_next = carry ? 10'd0 : r2[9:0];
        // zero quotient after division shows as 1.0
        if ((steps_a_reg != 3'd0) && (qc_next == 11'd0))
        begin
            qc_next = 11'd1;
            rf_next = 10'd0;
        end
    end

    always_comb
    begin
        frac_prod            = 23'(rf_b_reg) * 23'd5243;
        value_next.steps     = steps_b_reg;
        value_next.frac      = frac_prod[22:19];
        value_next.short_fmt = (steps_b_reg != 3'd0) && (qc_b_reg < 11'd10);
        if (value_next.short_fmt)
        begin
            value_next.value = qc_b_reg;
        end
        else
        begin
            value_next.value = qc_b_reg + {10'd0, (rf_b_reg > s2hr_pkg::HALF_LIMIT)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                va_reg <= in_valid;
            end
            if (adv_b)
            begin
                vb_reg <= va_reg;
            end
            if (adv_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && in_valid)
        begin
            steps_a_reg <= in_data.steps;
            q_a_reg     <= in_data.q;
            tens_a_reg  <= tens_next;
            r1_a_reg    <= r1_next;
        end
        if (adv_b && va_reg)
        begin
            steps_b_reg <= steps_a_reg;
            qc_b_reg    <= qc_next;
            rf_b_reg    <= rf_next;
        end
        if (adv_c && vb_reg)
        begin
            value_reg <= value_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_data  = value_reg;

endmodule

// File: hdl/s2hr_digits.sv
// decimal digit split and ascii text assembly, two stages
module s2hr_digits (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  s2hr_pkg::value_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [s2hr_pkg::CHAR_W-1:0]     text_pos0,
    output logic [s2hr_pkg::CHAR_W-1:0]     text_pos1,
    output logic [s2hr_pkg::CHAR_W-1:0]     text_pos2,
    output logic [s2hr_pkg::CHAR_W-1:0]     text_pos3,
    output logic [s2hr_pkg::CHAR_W-1:0]     unit_letter
);

    logic        va_reg;
    logic        vb_reg;
    logic        adv_a;
    logic        adv_b;

    s2hr_pkg::value_t val_a_reg;
    logic [3:0]  hund_a_reg;
    logic [6:0]  rem_a_reg;
    logic [23:0] hund_prod;
    logic [3:0]  hund_next;
    logic [10:0] hund_x100;
    logic [10:0] rem_full;

    logic [14:0] tn_prod;
    logic [3:0]  tn;
    logic [6:0]  tn_x10;
    logic [6:0]  un_full;
    logic [3:0]  un;

    logic [7:0]  pos0_reg;
    logic [7:0]  pos1_reg;
    logic [7:0]  pos2_reg;
    logic [7:0]  pos3_reg;
    logic [7:0]  unit_reg;
    logic [7:0]  pos0_next;
    logic [7:0]  pos1_next;
    logic [7:0]  pos2_next;
    logic [7:0]  pos3_next;

    assign adv_b    = !vb_reg || out_ready;
    assign adv_a    = !va_reg || adv_b;
    assign in_ready = adv_a;

    always_comb
    begin
        hund_prod = 24'(in_data.value) * 24'd5243;
        hund_next = hund_prod[22:19];
        hund_x100 = ({7'd0, hund_next} << 6) + ({7'd0, hund_next} << 5)
                  + ({7'd0, hund_next} << 2);
        rem_full  = in_data.value - hund_x100;
    end

    always_comb
    begin
        tn_prod = 15'(rem_a_reg) * 15'd205;
        tn      = tn_prod[14:11];
        tn_x10  = ({3'd0, tn} << 3) + ({3'd0, tn} << 1);
        un_full = rem_a_reg - tn_x10;
        un      = un_full[3:0];
        if (val_a_reg.short_fmt)
        begin
            pos0_next = s2hr_pkg::CHAR_SPACE;
            pos1_next = s2hr_pkg::digit_char(val_a_reg.value[3:0]);
            pos2_next = s2hr_pkg::CHAR_POINT;
            pos3_next = s2hr_pkg::digit_char(val_a_reg.frac);
        end
        else
        begin
            // only 1000 reaches four digits
            pos0_next = (hund_a_reg == 4'd10) ? s2hr_pkg::CHAR_ONE : s2hr_pkg::CHAR_SPACE;
            if (hund_a_reg == 4'd10)
            begin
                pos1_next = s2hr_pkg::CHAR_ZERO;
            end
            else if (val_a_reg.value >= 11'd100)
            begin
                pos1_next = s2hr_pkg::digit_char(hund_a_reg);
            end
            else
            begin
                pos1_next = s2hr_pkg::CHAR_SPACE;
            end
            pos2_next = (val_a_reg.value >= 11'd10) ? s2hr_pkg::digit_char(tn)
                                                    : s2hr_pkg::CHAR_SPACE;
            pos3_next = s2hr_pkg::digit_char(un);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                va_reg <= in_valid;
            end
            if (adv_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && in_valid)
        begin
            val_a_reg  <= in_data;
            hund_a_reg <= hund_next;
            rem_a_reg  <= rem_full[6:0];
        end
        if (adv_b && va_reg)
        begin
            pos0_reg <= pos0_next;
            pos1_reg <= pos1_next;
            pos2_reg <= pos2_next;
            pos3_reg <= pos3_next;
            unit_reg <= s2hr_pkg::unit_char(val_a_reg.steps);
        end
    end

    assign out_valid   = vb_reg;
    assign text_pos0   = pos0_reg;
    assign text_pos1   = pos1_reg;
    assign text_pos2   = pos2_reg;
    assign text_pos3   = pos3_reg;
    assign unit_letter = unit_reg;

endmodule

// File: hdl/size_to_human_readable.sv
// top level: byte count to four right-aligned characters plus a unit letter
// pipeline depth: seven register stages
// throughput: one item per cycle while out_ready is high; every stage has its own valid bit and the
//   ready chain lets a stage refill as soon as its item moves on
// reset: rst_n async active low clears all valid bits; data registers are not reset
// outputs hold their value while out_valid is high and out_ready is low
`include "assert_macros.svh"

module size_to_human_readable (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [s2hr_pkg::COUNT_W-1:0]    byte_count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [s2hr_pkg::CHAR_W-1:0]     text_pos0,
    output logic [s2hr_pkg::CHAR_W-1:0]     text_pos1,
    output logic [s2hr_pkg::CHAR_W-1:0]     text_pos2,
    output logic [s2hr_pkg::CHAR_W-1:0]     text_pos3,
    output logic [s2hr_pkg::CHAR_W-1:0]     unit_letter
);

    // range -> round handoff
    logic               range_valid;
    logic               range_ready;
    s2hr_pkg::range_t   range_data;

    // round -> digits handoff
    logic               value_valid;
    logic               value_ready;
    s2hr_pkg::value_t   value_data;

    // stages 1-2: count the 1024 divisions against the 1000 << 10k
    // thresholds, then pick the quotient and last remainder bit fields
    s2hr_range u_range (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_count (byte_count),
        .out_valid  (range_valid),
        .out_ready  (range_ready),
        .out_data   (range_data)
    );

    // stages 3-5: half-up rounding at tens then hundreds, carry into the
    // quotient, then decide between d.f and integer form
    s2hr_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (range_valid),
        .in_ready  (range_ready),
        .in_data   (range_data),
        .out_valid (value_valid),
        .out_ready (value_ready),
        .out_data  (value_data)
    );

    // stages 6-7: split into decimal digits and build the ascii text;
    // the last stage is the output register
    s2hr_digits u_digits (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (value_valid),
        .in_ready    (value_ready),
        .in_data     (value_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .text_pos0   (text_pos0),
        .text_pos1   (text_pos1),
        .text_pos2   (text_pos2),
        .text_pos3   (text_pos3),
        .unit_letter (unit_letter)
    );

    // last position always carries a digit
    `S2HR_IMPLIES(a_pos3_digit, clk, rst_n, out_valid, (text_pos3 >= s2hr_pkg::CHAR_ZERO) && (text_pos3 <= 8'h39))

    // the one-decimal form never shows a zero leading digit and never uses bytes
    `S2HR_IMPLIES(a_short_form, clk, rst_n, out_valid && (text_pos2 == s2hr_pkg::CHAR_POINT), (text_pos0 == s2hr_pkg::CHAR_SPACE) && (text_pos1 != s2hr_pkg::CHAR_ZERO) && (unit_letter != 8'h42))

    // only a rounded 1000 fills the first position
    `S2HR_IMPLIES(a_four_digits, clk, rst_n, out_valid && (text_pos0 != s2hr_pkg::CHAR_SPACE), (text_pos0 == s2hr_pkg::CHAR_ONE) && (text_pos1 == s2hr_pkg::CHAR_ZERO) && (text_pos2 == s2hr_pkg::CHAR_ZERO) && (text_pos3 == s2hr_pkg::CHAR_ZERO))

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the byte count to size text formatter
`timescale 1ns / 1ps

module testbench;

    localparam int COUNT_W       = s2hr_pkg::COUNT_W;
    localparam int CHAR_W        = s2hr_pkg::CHAR_W;
    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1525;
    // random item index where the receiver starts its long hold-off
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 80;
    // random item index after which the sender waits for every result
    localparam int DRAIN_AT      = 900;
    // seven pipeline stages, leave a margin after the last result
    localparam int SETTLE_CYCLES = 20;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int PRINT_CAP     = 200;
    localparam int NUM_FIELDS    = 5;
    localparam int NUM_UNITS     = 6;

    // unit letters by number of 1024 divisions, none after the sixth
    localparam logic [8*NUM_UNITS-1:0] UNIT_LETTERS = "BKMGTP";
    localparam logic [CHAR_W-1:0]      NO_UNIT      = 8'h00;

    // five output characters, position 0 in the top byte
    typedef struct packed {
        logic [CHAR_W-1:0] pos0;
        logic [CHAR_W-1:0] pos1;
        logic [CHAR_W-1:0] pos2;
        logic [CHAR_W-1:0] pos3;
        logic [CHAR_W-1:0] unit;
    } size_text_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        size_text_t         text;
    } pending_entry_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               typed;
        size_text_t         want;
    } directed_row_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_MOSTLY,
        READY_PERIODIC
    } ready_mode_t;

    // directed items: extremes, rounding corners, carries, every unit, sixth step;
    // rows with typed set carry an expected text, the rest go through the predictor
    localparam directed_row_t DIRECTED [25] = '{
        '{63'd0,                 1'b1, "   0B"},
        '{63'd1,                 1'b1, "   1B"},
        '{63'd100,               1'b1, " 100B"},
        '{63'd999,               1'b1, " 999B"},
        '{63'd1000,              1'b1, " 1.0K"},
        '{63'd1023,              1'b0, 40'd0},
        '{63'd1024,              1'b1, " 1.0K"},
        '{63'd1069,              1'b0, 40'd0},
        '{63'd1173,              1'b0, 40'd0},
        '{63'd1536,              1'b1, " 1.5K"},
        '{63'd6065,              1'b0, 40'd0},
        '{63'd10239,             1'b0, 40'd0},
        '{63'd10240,             1'b1, "  10K"},
        '{63'd10753,             1'b0, 40'd0},
        '{63'd1023476,           1'b0, 40'd0},
        '{63'd1023477,           1'b0, 40'd0},
        '{63'd1023999,           1'b0, 40'd0},
        '{63'd1024000,           1'b0, 40'd0},
        '{(63'd1 << 20),         1'b1, " 1.0M"},
        '{(63'd1 << 30),         1'b1, " 1.0G"},
        '{(63'd1 << 40),         1'b1, " 1.0T"},
        '{(63'd1 << 50),         1'b1, " 1.0P"},
        '{(63'd999 << 50),       1'b0, 40'd0},
        '{(63'd1000 << 50),      1'b0, 40'd0},
        '{63'h7FFF_FFFF_FFFF_FFFF, 1'b1, {" 8.0", NO_UNIT}}
    };

    // remainders around both rounding digits and the carry
    localparam int unsigned REM_EDGES [18] = '{
        0, 4, 5, 44, 45, 49, 50, 94, 95, 99, 100, 449, 450, 499, 500, 501, 995, 1023
    };
    // quotients around the short form, the long form and the next unit
    localparam int unsigned QUOT_EDGES [8] = '{1, 9, 10, 99, 100, 999, 1000, 1023};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [COUNT_W-1:0] byte_count;
    logic               out_valid;
    logic               out_ready;
    logic [CHAR_W-1:0]  text_pos0;
    logic [CHAR_W-1:0]  text_pos1;
    logic [CHAR_W-1:0]  text_pos2;
    logic [CHAR_W-1:0]  text_pos3;
    logic [CHAR_W-1:0]  unit_letter;

    // request from the sender side for one long receiver hold-off
    logic               hold_req;

    pending_entry_t     pending_text [$];
    int                 mismatch_count = 0;
    pending_entry_t     due;
    size_text_t         seen;
    string              field_names [NUM_FIELDS] = '{
        "text_pos0", "text_pos1", "text_pos2", "text_pos3", "unit_letter"
    };

    size_to_human_readable uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_count  (byte_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .text_pos0   (text_pos0),
        .text_pos1   (text_pos1),
        .text_pos2   (text_pos2),
        .text_pos3   (text_pos3),
        .unit_letter (unit_letter)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // expected text for one byte count
    function automatic size_text_t format_size(input logic [COUNT_W-1:0] count);
        logic [63:0]       quot;
        logic [63:0]       rem;
        logic [63:0]       digit;
        int                steps;
        int                pos;
        bit                point_form;
        logic [CHAR_W-1:0] txt [4];
        size_text_t        res;
        quot       = {1'b0, count};
        rem        = '0;
        steps      = 0;
        point_form = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            txt[i] = s2hr_pkg::CHAR_SPACE;
        end
        if (quot >= 64'd1000)
        begin
            // divide down, keeping only the last remainder
            while (quot > 64'd999)
            begin
                rem  = quot % 64'd1024;
                quot = quot / 64'd1024;
                steps++;
            end
            // half-up at the units digit, then at the tens digit
            digit = rem % 64'd10;
            if (digit > 64'd4)
                rem = rem + 64'd10 - digit;
            digit = (rem / 64'd10) % 64'd10;
            if (digit > 64'd4)
                rem = rem + (64'd10 - digit) * 64'd10;
            // remainder overflow carries into the quotient
            if (rem > 64'd999)
            begin
                quot = quot + 64'd1;
                rem  = '0;
            end
            if (quot == 64'd0)
            begin
                quot = 64'd1;
                rem  = '0;
            end
            if (quot < 64'd10)
            begin
                // one decimal: " d.f"
                point_form = 1'b1;
                txt[1] = s2hr_pkg::CHAR_ZERO + quot[7:0];
                txt[2] = s2hr_pkg::CHAR_POINT;
                txt[3] = s2hr_pkg::CHAR_ZERO + 8'((rem / 64'd100) % 64'd10);
            end
            else if (rem > 64'd500)
            begin
                quot = quot + 64'd1;
            end
        end
        if (!point_form)
        begin
            // right-aligned integer ending at position 3
            if (quot == 64'd0)
                txt[3] = s2hr_pkg::CHAR_ZERO;
            pos = 3;
            while (quot > 64'd0 && pos >= 0)
            begin
                txt[pos] = s2hr_pkg::CHAR_ZERO + 8'(quot % 64'd10);
                quot     = quot / 64'd10;
                pos--;
            end
        end
        res.pos0 = txt[0];
        res.pos1 = txt[1];
        res.pos2 = txt[2];
        res.pos3 = txt[3];
        res.unit = (steps < NUM_UNITS) ? UNIT_LETTERS[8*NUM_UNITS-1-8*steps -: 8] : NO_UNIT;
        return res;
    endfunction

    // random byte count: half built from a quotient and a remainder, often near the
    // rounding corners at some unit, the rest full-range, random-width or short
    function automatic logic [COUNT_W-1:0] random_count();
        logic [63:0] wide;
        logic [63:0] quot;
        logic [63:0] rem;
        logic [63:0] low;
        int          pick;
        int          k;
        wide = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return wide[COUNT_W-1:0];
        if (pick < 35)
            return wide[COUNT_W-1:0] >> $urandom_range(0, COUNT_W - 1);
        if (pick < 50)
            return COUNT_W'($urandom_range(0, 2047));
        k    = $urandom_range(1, 6);
        quot = ($urandom_range(0, 2) == 0) ? 64'(QUOT_EDGES[$urandom_range(0, 7)])
                                           : 64'($urandom_range(1, 1023));
        rem  = ($urandom_range(0, 1) == 0) ? 64'(REM_EDGES[$urandom_range(0, 17)])
                                           : 64'($urandom_range(0, 1023));
        low  = wide & ((64'd1 << (10 * (k - 1))) - 64'd1);
        return COUNT_W'((quot << (10 * k)) | (rem << (10 * (k - 1))) | low);
    endfunction

    task automatic report_mismatch(input string msg);
        // keep the log short if the block is badly broken
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // offer one item and hold it until accepted, then queue what it should give
    task automatic offer_count(input logic [COUNT_W-1:0] count, input logic typed,
                               input size_text_t want);
        pending_entry_t entry;
        in_valid   <= 1'b1;
        byte_count <= count;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        entry.count = count;
        entry.text  = typed ? want : format_size(count);
        pending_text.push_back(entry);
    endtask

    // result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            seen = {text_pos0, text_pos1, text_pos2, text_pos3, unit_letter};
            if (pending_text.size() == 0)
            begin
                report_mismatch($sformatf("result %h with no item pending", seen));
            end
            else
            begin
                due = pending_text.pop_front();
                for (int f = 0; f < NUM_FIELDS; f++)
                begin
                    if (seen[8*NUM_FIELDS-1-8*f -: 8] !== due.text[8*NUM_FIELDS-1-8*f -: 8])
                        report_mismatch($sformatf("count %0d %s got %h expected %h",
                            due.count, field_names[f],
                            seen[8*NUM_FIELDS-1-8*f -: 8],
                            due.text[8*NUM_FIELDS-1-8*f -: 8]));
                end
            end
        end
    end

    // receiver: changes its stall pattern every so often, and once holds off
    // for a long stretch when the sender asks, so the pipeline backs up
    initial
    begin : receiver
        ready_mode_t mode;
        int          left;
        int          phase;
        int          period;
        bit          hold_taken;
        mode       = READY_ALWAYS;
        left       = 0;
        phase      = 0;
        period     = 2;
        hold_taken = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                // long hold-off, counted here while the sender keeps offering
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode   = ready_mode_t'($urandom_range(0, 3));
                    left   = $urandom_range(20, 200);
                    period = $urandom_range(2, 5);
                end
                left--;
                phase++;
                case (mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    READY_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
                    default:      out_ready <= (phase % period == 0);
                endcase
            end
        end
    end

    // sender: reset, directed table, then random items in bursts with gaps
    initial
    begin : sender
        int idx;
        int burst;
        int gap;
        bit hold_done;
        bit drained;
        idx       = 0;
        hold_done = 1'b0;
        drained   = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        byte_count <= '0;
        hold_req   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, back to back
        foreach (DIRECTED[i])
            offer_count(DIRECTED[i].count, DIRECTED[i].typed, DIRECTED[i].want);
        in_valid <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);

        // random part
        while (idx < RANDOM_ITEMS)
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            if (!hold_done && idx >= HOLD_AT)
            begin
                // ask for the long stall and keep offering through it
                hold_req <= 1'b1;
                hold_done = 1'b1;
                burst     = 48;
            end
            for (int b = 0; b < burst && idx < RANDOM_ITEMS; b++)
            begin
                offer_count(random_count(), 1'b0, '0);
                idx++;
            end
            if (!drained && idx >= DRAIN_AT)
            begin
                // pause until the pipeline has handed back every result
                drained = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_text.size() != 0)
                    @(posedge clk);
            end
            else
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;

        // wait for the last results, then wait out SETTLE_CYCLES for anything stray
        while (pending_text.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending_text.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/s2hr_pkg.sv
hdl/s2hr_range.sv
hdl/s2hr_round.sv
hdl/s2hr_digits.sv
hdl/size_to_human_readable.sv
tb/sv/testbench.sv
